FILE: rtl/substring_deleter_macros.svh
// Assertion macros shared by the substring deleter RTL.
`ifndef SUBSTRING_DELETER_MACROS_SVH
`define SUBSTRING_DELETER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SUBDEL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SUBDEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/subdel_pkg.sv
// Types and constants shared by the substring deleter modules.
package subdel_pkg;

    localparam int CODE_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int LEN_W     = 4;

    localparam logic REG_IDX_PATTERN = 1'b0;
    localparam logic REG_IDX_LENGTH  = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              has_char;
        logic              is_last;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic              out_valid;
        logic              out_last;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic [CODE_W-1:0] code;
    } cell_ctl_t;

endpackage

FILE: rtl/subdel_cell.sv
// One window cell: holds a character, compares it with its pattern byte.
module subdel_cell import subdel_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
) (
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  logic [CNT_W-1:0]  count,
    input  logic              in_use,
    input  logic [CODE_W-1:0] pat_byte,
    input  logic [CODE_W-1:0] from_next,
    output logic [CODE_W-1:0] eff,
    output logic              match_ok
);

    logic [CODE_W-1:0] data_reg;
    logic [CODE_W-1:0] data_next;

    always_comb begin
        eff       = (ctl.load && (count == CNT_W'(IDX))) ? ctl.code : data_reg;
        match_ok  = !in_use || (eff == pat_byte);
        data_next = ctl.shift ? from_next : eff;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: rtl/subdel_outq.sv
// Two-entry output queue that decouples the result channel from the window.
module subdel_outq import subdel_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    output logic      has_room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    out_item_t  head_reg;
    out_item_t  head_next;
    out_item_t  spare_reg;
    out_item_t  spare_next;
    logic       pop;

    always_comb begin
        pop        = (occ_reg != 2'd0) && m_ready;
        occ_next   = occ_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        case (occ_reg)
            2'd0: begin
                if (push) begin
                    head_next = push_item;
                    occ_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = push_item;
                end else if (push) begin
                    spare_next = push_item;
                    occ_next   = 2'd2;
                end else if (pop) begin
                    occ_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = spare_reg;
                    occ_next  = 2'd1;
                end
            end
            default: begin
                occ_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 2'd0;
        end else begin
            occ_reg <= occ_next;
        end
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign has_room = (occ_reg != 2'd2);
    assign m_valid  = (occ_reg != 2'd0);
    assign m_item   = head_reg;

endmodule

FILE: rtl/substring_deleter.sv
// Top level of the streaming substring deleter.
//
// Characters arrive on the s_ channel, one transfer per character, and the
// surviving characters leave on the m_ channel, one transfer per character.
// A transfer with has_char low carries no character; is_last closes a string.
// The window of cells holds back up to the pattern length minus one
// characters, so a character leaves after that many later characters have
// arrived and then passes through the output queue. Input is accepted every
// cycle while no flush runs and the two-entry output queue has room. A last
// transfer that leaves characters in the window starts a flush, during which
// s_ready is low, that emits one held character per cycle while the queue
// has room, at most seven. A string whose characters were all removed ends
// with a bare end marker. If the receiver stalls, the queue fills and s_ready
// drops after two results wait. Reset empties the window and the queue and
// clears both registers; a write to pattern_length also empties the window.
module substring_deleter import subdel_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [PATTERN_W-1:0] pwdata,
    output logic [PATTERN_W-1:0] prdata,
    output logic                 pready
);

`include "substring_deleter_macros.svh"

    localparam int WIN_CAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int CNT_W   = $clog2(WIN_CAP + 1);

    logic [PATTERN_W-1:0] pattern_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 flush_reg;
    logic                 flush_next;

    logic                 cfg_wr;
    logic                 len_wr;
    logic [CNT_W-1:0]     len_w;
    logic                 room;
    logic                 acc;
    logic                 load;
    logic                 pass;
    logic                 full;
    logic                 hit;
    logic                 miss;
    logic                 flush_push;
    logic [CNT_W-1:0]     count_after;
    logic                 push;
    out_item_t            push_item;
    cell_ctl_t            ctl;

    logic [CODE_W-1:0]    eff [WIN_CAP];
    logic [WIN_CAP-1:0]   match_vec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign len_wr = cfg_wr && (paddr[3] == REG_IDX_LENGTH);
    assign prdata = (paddr[3] == REG_IDX_LENGTH) ? PATTERN_W'(length_reg) : pattern_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_IDX_PATTERN) begin
                pattern_reg <= pwdata;
            end else begin
                length_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        len_w = (length_reg > LEN_W'(WIN_CAP)) ? CNT_W'(WIN_CAP) : length_reg[CNT_W-1:0];
        s_ready    = !flush_reg && room;
        acc        = s_valid && s_ready;
        load       = acc && s_item.has_char && (len_w != '0);
        pass       = acc && s_item.has_char && (len_w == '0);
        full       = load && ((count_reg + CNT_W'(1)) == len_w);
        hit        = full && (&match_vec);
        miss       = full && !(&match_vec);
        flush_push = flush_reg && room;

        if (!load) begin
            count_after = count_reg;
        end else if (hit) begin
            count_after = '0;
        end else if (miss) begin
            count_after = count_reg;
        end else begin
            count_after = count_reg + CNT_W'(1);
        end

        push      = 1'b0;
        push_item = '0;
        if (flush_push) begin
            push                = 1'b1;
            push_item.out_code  = eff[0];
            push_item.out_valid = 1'b1;
            push_item.out_last  = (count_reg == CNT_W'(1));
        end else if (pass) begin
            push                = 1'b1;
            push_item.out_code  = s_item.char_code;
            push_item.out_valid = 1'b1;
            push_item.out_last  = s_item.is_last;
        end else if (miss) begin
            push                = 1'b1;
            push_item.out_code  = eff[0];
            push_item.out_valid = 1'b1;
            push_item.out_last  = s_item.is_last && (count_after == '0);
        end else if (acc && s_item.is_last && (count_after == '0)) begin
            push               = 1'b1;
            push_item.out_last = 1'b1;
        end

        ctl.load  = load;
        ctl.shift = miss || flush_push;
        ctl.code  = s_item.char_code;

        count_next = count_reg;
        flush_next = flush_reg;
        if (len_wr) begin
            count_next = '0;
            flush_next = 1'b0;
        end else if (flush_push) begin
            count_next = count_reg - CNT_W'(1);
            flush_next = (count_reg != CNT_W'(1));
        end else if (acc) begin
            count_next = count_after;
            flush_next = s_item.is_last && (count_after != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flush_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            flush_reg <= flush_next;
        end
    end

    for (genvar g = 0; g < WIN_CAP; g++) begin : g_cell
        logic [CODE_W-1:0] from_next;
        if (g == WIN_CAP - 1) begin : g_tail
            assign from_next = '0;
        end else begin : g_link
            assign from_next = eff[g+1];
        end
        subdel_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count_reg),
            .in_use    (CNT_W'(g) < len_w),
            .pat_byte  (pattern_reg[CODE_W*g +: CODE_W]),
            .from_next (from_next),
            .eff       (eff[g]),
            .match_ok  (match_vec[g])
        );
    end

    subdel_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .has_room  (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    `SUBDEL_ASSERT_SAME(a_count_ok, 1'b1, count_reg < len_w || count_reg == '0, "Count too high.")
    `SUBDEL_ASSERT_SAME(a_flush_has_data, flush_reg, count_reg != '0, "Empty window in flush.")
    `SUBDEL_ASSERT_NEXT(a_hit_clears, hit, count_reg == '0, "A match did not empty the window.")
    `SUBDEL_ASSERT_SAME(a_push_room, push, room, "A result was pushed into a full output queue.")

endmodule

FILE: test/substring_deleter_tb.sv
// Self-checking testbench for the streaming substring deleter.
module testbench import subdel_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD   = 4;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 300;
    localparam longint      LIMIT_NS      = 4_000_000;
    localparam int unsigned WIN_MAX       = 8;
    localparam logic [3:0]  ADDR_PATTERN  = {REG_IDX_PATTERN, 3'b000};
    localparam logic [3:0]  ADDR_LENGTH   = {REG_IDX_LENGTH, 3'b000};

    typedef enum int unsigned {
        STYLE_ALPHA,
        STYLE_RANDOM,
        STYLE_ONES,
        STYLE_ZEROS
    } pat_style_e;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [3:0]           paddr   = '0;
    logic [PATTERN_W-1:0] pwdata  = '0;
    logic [PATTERN_W-1:0] prdata;
    logic                 pready;

    logic [63:0] cfg_pattern;
    logic [3:0]  cfg_length;
    logic [7:0]  win_chars [WIN_MAX];
    int unsigned win_fill;
    out_item_t   survivors_q [$];
    out_item_t   want;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;
    event        hold_go;

    int unsigned err_count       = 0;
    int unsigned items_sent      = 0;
    int unsigned strings_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned configs_written = 0;

    substring_deleter u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic in_item_t make_item(input logic [7:0] code, input bit hc, input bit last);
        in_item_t it;
        it.char_code = code;
        it.has_char  = hc;
        it.is_last   = last;
        return it;
    endfunction

    function automatic int unsigned active_len();
        return (cfg_length > WIN_MAX) ? WIN_MAX : int'(cfg_length);
    endfunction

    task automatic push_survivor(input logic [7:0] code, input logic valid);
        out_item_t r;
        r.out_code  = code;
        r.out_valid = valid;
        r.out_last  = 1'b0;
        survivors_q.push_back(r);
    endtask

    task automatic predict_survivors(input in_item_t it);
        int unsigned len;
        int unsigned produced;
        bit          hit;
        len      = active_len();
        produced = 0;
        if (len == 0) begin
            win_fill = 0;
        end else if (win_fill >= len) begin
            win_fill = win_fill % len;
        end
        if (it.has_char) begin
            if (len == 0) begin
                push_survivor(it.char_code, 1'b1);
                produced++;
            end else begin
                win_chars[win_fill] = it.char_code;
                win_fill++;
                if (win_fill >= len) begin
                    hit = 1'b1;
                    for (int unsigned i = 0; i < len; i++) begin
                        if (win_chars[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
                    end
                    if (hit) begin
                        win_fill = 0;
                    end else begin
                        push_survivor(win_chars[0], 1'b1);
                        produced++;
                        for (int unsigned i = 1; i < win_fill; i++) win_chars[i-1] = win_chars[i];
                        win_fill--;
                    end
                end
            end
        end
        if (it.is_last) begin
            for (int unsigned i = 0; i < win_fill; i++) begin
                push_survivor(win_chars[i], 1'b1);
                produced++;
            end
            win_fill = 0;
            if (produced == 0) push_survivor(8'h00, 1'b0);
            survivors_q[survivors_q.size()-1].out_last = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    task automatic send_transfer(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_survivors(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (survivors_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PATTERN) begin
            cfg_pattern = data;
        end else if (addr == ADDR_LENGTH) begin
            cfg_length = data[3:0];
            win_fill   = 0;
        end
        configs_written++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_text(input logic [7:0] chars [$], input bit close);
        for (int i = 0; i < chars.size(); i++) begin
            send_transfer(make_item(chars[i], 1'b1, close && (i == chars.size() - 1)));
        end
        if (close) strings_sent++;
    endtask

    task automatic randomize_config(output pat_style_e style);
        logic [63:0] bytes;
        logic [3:0]  len;
        style = pat_style_e'($urandom_range(3));
        case (style)
            STYLE_ALPHA: begin
                for (int i = 0; i < 8; i++) bytes[8*i +: 8] = 8'(8'h61 + $urandom_range(2));
            end
            STYLE_RANDOM: bytes = {$urandom, $urandom};
            STYLE_ONES:   bytes = '1;
            default:      bytes = '0;
        endcase
        case ($urandom_range(9))
            0:       len = 4'd0;
            1:       len = 4'($urandom_range(9, 15));
            2, 3:    len = 4'($urandom_range(5, 8));
            default: len = 4'($urandom_range(1, 4));
        endcase
        write_register(ADDR_PATTERN, bytes);
        write_register(ADDR_LENGTH, {60'd0, len});
    endtask

    task automatic send_random_string(input pat_style_e style);
        int unsigned n_chars;
        int unsigned ptr;
        int unsigned alen;
        logic [7:0]  code;
        bit          hc;
        n_chars = $urandom_range(1, 12);
        alen    = active_len();
        ptr     = 0;
        for (int unsigned k = 0; k < n_chars; k++) begin
            if ($urandom_range(99) < 8) begin
                send_transfer(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
            end
            if (alen > 0 && $urandom_range(99) < 55) begin
                code = cfg_pattern[8*ptr +: 8];
                ptr  = ($urandom_range(9) == 0) ? 0 : (ptr + 1) % alen;
            end else if (style == STYLE_ALPHA) begin
                code = 8'(8'h61 + $urandom_range(2));
            end else begin
                code = 8'($urandom_range(255));
            end
            hc = (k + 1 < n_chars) || ($urandom_range(3) != 0);
            send_transfer(make_item(code, hc, k + 1 == n_chars));
        end
        strings_sent++;
    endtask

    task automatic test_passthrough_at_reset();
        send_transfer(make_item(8'h00, 1'b1, 1'b0));
        send_transfer(make_item(8'hFF, 1'b1, 1'b0));
        send_transfer(make_item(8'hA5, 1'b0, 1'b0));
        send_transfer(make_item(8'h5A, 1'b1, 1'b1));
        send_transfer(make_item(8'hC3, 1'b0, 1'b1));
        strings_sent += 2;
        drain_results();
    endtask

    task automatic test_basic_deletion();
        write_register(ADDR_PATTERN, 64'h6261);
        write_register(ADDR_LENGTH, 64'd2);
        send_text('{8'h61, 8'h61, 8'h62, 8'h62}, 1'b1);
        send_text('{8'h61, 8'h62, 8'h61, 8'h62}, 1'b1);
        drain_results();
    endtask

    task automatic test_length_clamp();
        write_register(ADDR_PATTERN, 64'hFF00_FF00_FF00_FF00);
        write_register(ADDR_LENGTH, 64'd15);
        send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
        drain_results();
    endtask

    task automatic test_pattern_longer_than_text();
        write_register(ADDR_PATTERN, 64'h65_6463_6261);
        write_register(ADDR_LENGTH, 64'd5);
        send_text('{8'h61, 8'h62, 8'h63}, 1'b1);
        drain_results();
    endtask

    task automatic test_rewrite_mid_string();
        write_register(ADDR_PATTERN, 64'h7A7978);
        write_register(ADDR_LENGTH, 64'd3);
        send_text('{8'h78, 8'h79}, 1'b0);
        drain_results();
        // The held window survives a new pattern and is compared against it.
        write_register(ADDR_PATTERN, 64'h777978);
        send_text('{8'h77}, 1'b1);
        drain_results();
        send_text('{8'h61, 8'h62}, 1'b0);
        drain_results();
        // Rewriting the length empties the window.
        write_register(ADDR_LENGTH, 64'd3);
        send_text('{8'h63}, 1'b1);
        drain_results();
    endtask

    task automatic test_random_strings(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned n_items);
        pat_style_e  style;
        int unsigned stop_at;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at      = items_sent + n_items;
        drain_results();
        randomize_config(style);
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                drain_results();
                randomize_config(style);
            end
            send_random_string(style);
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_register(ADDR_PATTERN, 64'h6261);
        write_register(ADDR_LENGTH, 64'd2);
        -> hold_go;
        for (int k = 0; k < 60; k++) begin
            send_transfer(make_item(8'(8'h61 + $urandom_range(2)), 1'b1, k == 59));
        end
        strings_sent++;
        drain_results();
    endtask

    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge aclk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (survivors_q.size() == 0) begin
                report_mismatch("result with nothing expected", int'(m_item), 0);
            end else begin
                want = survivors_q.pop_front();
                results_checked++;
                if (m_item.out_code !== want.out_code)
                    report_mismatch("out_code", int'(m_item.out_code), int'(want.out_code));
                if (m_item.out_valid !== want.out_valid)
                    report_mismatch("out_valid", int'(m_item.out_valid), int'(want.out_valid));
                if (m_item.out_last !== want.out_last)
                    report_mismatch("out_last", int'(m_item.out_last), int'(want.out_last));
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        cfg_pattern = '0;
        cfg_length  = '0;
        win_fill    = 0;
        aresetn     = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct  = 23;
        rx_stall_pct = 54;
        test_passthrough_at_reset();
        test_basic_deletion();
        test_length_clamp();
        test_pattern_longer_than_text();
        test_rewrite_mid_string();
        test_random_strings(23, 54, 70);
        test_random_strings(54, 23, 70);
        test_random_strings(0, 0, 70);
        test_backpressure();

        if (survivors_q.size() != 0)
            report_mismatch("results never delivered", survivors_q.size(), 0);
        $display("Sent %0d strings in %0d transfers under %0d register writes.",
                 strings_sent, items_sent, configs_written);
        $display("Checked %0d surviving characters and end markers, %0d mismatches.",
                 results_checked, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
